@@ rtl/mst_pkg.sv @@
// Shared item types and code constants for the multi-slot timer.
package mst_pkg;

  // Input item operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result item kinds
  localparam logic [2:0] K_START_OK    = 3'd0;
  localparam logic [2:0] K_START_FAIL  = 3'd1;
  localparam logic [2:0] K_CANCEL_OK   = 3'd2;
  localparam logic [2:0] K_CANCEL_FAIL = 3'd3;
  localparam logic [2:0] K_FIRED       = 3'd4;
  localparam logic [2:0] K_TICK_DONE   = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic        periodic;
    logic [31:0] interval;
    logic [15:0] handler_tag;
    logic [5:0]  slot;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot_out;
    logic [15:0] tag_out;
    logic        last;
  } rsp_t;

endpackage

@@ rtl/mst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mst_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mst_cmp.sv @@
// Shared expiry compare: wrapping elapsed time against the slot interval.
module mst_cmp #(
  parameter int TB = 32
) (
  input  logic [TB-1:0] now_t,
  input  logic [TB-1:0] start_t,
  input  logic [TB-1:0] ivl,
  output logic          fire
);

  logic [TB-1:0] elapsed;

  // Subtract wraps modulo 2^TB, then one unsigned compare
  always_comb begin
    elapsed = now_t - start_t;
    fire    = (elapsed >= ivl);
  end

endmodule

@@ rtl/multi_slot_software_timer_top.sv @@
// Start checks one slot per cycle from slot 0 until it finds a free one.
// Tick compares one slot per cycle in the shared expiry unit, holding on a fired
// slot while the result register waits on rsp_ready, then gives a tick-done result.
// Throughput: one item at a time; req_ready is high only between items.
// Reset clears all slots to free, the busy count and the result valid flag;
// the slot RAM is not cleared and its read data is used only for busy slots.
module multi_slot_software_timer_top #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mst_pkg::rsp_t rsp
);
  import mst_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = 16 + 2 * TB;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CANCEL,
    S_TICK,
    S_DONE
  } state_t;

  state_t        state;
  req_t          item;
  logic [IW-1:0] idx;
  logic [SLOTS-1:0] busy;
  logic [SLOTS-1:0] periodic;
  logic [CW-1:0] busy_count;

  logic [IW-1:0] rd_addr;
  logic [RW-1:0] rd_data;
  logic          we;
  logic [RW-1:0] wdata;
  logic [TB-1:0] rd_start;
  logic [TB-1:0] rd_ivl;
  logic [15:0]   rd_tag;
  logic [TB-1:0] now_t;
  logic          fire;
  logic          out_free;
  logic          start_bad;
  logic          hit;
  logic          adv;
  logic          cancel_bad;
  logic [IW-1:0] cidx;
  logic          rsp_load;

  // Slot RAM word: tag, interval, start time
  mst_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mst_cmp #(.TB(TB)) u_cmp (
    .now_t   (now_t),
    .start_t (rd_start),
    .ivl     (rd_ivl),
    .fire    (fire)
  );

  // Decode of read data and per-cycle conditions
  always_comb begin
    rd_start   = rd_data[TB-1:0];
    rd_ivl     = rd_data[2*TB-1:TB];
    rd_tag     = rd_data[RW-1:2*TB];
    now_t      = TB'(item.now);
    out_free   = !rsp_valid || rsp_ready;
    start_bad  = (item.handler_tag == 16'd0) || (busy_count >= CW'(SLOTS));
    hit        = busy[idx] && fire;
    adv        = !hit || out_free;
    cancel_bad = (item.slot >= 6'(SLOTS));
    cidx       = item.slot[IW-1:0];
  end

  // A new result item enters the output register this cycle
  always_comb begin
    unique case (state)
      S_START:  rsp_load = out_free && (start_bad || !busy[idx]);
      S_CANCEL: rsp_load = out_free;
      S_TICK:   rsp_load = hit && out_free;
      S_DONE:   rsp_load = out_free;
      default:  rsp_load = 1'b0;
    endcase
  end

  // Read address runs one slot ahead while the tick scan advances
  always_comb begin
    rd_addr = idx;
    if (state == S_IDLE) begin
      rd_addr = '0;
    end else if (state == S_TICK && adv && idx != LAST_IDX) begin
      rd_addr = idx + IW'(1);
    end
  end

  // RAM write: new slot on start, restart time on periodic fire
  always_comb begin
    we    = 1'b0;
    wdata = {item.handler_tag, TB'(item.interval), TB'(item.now)};
    if (state == S_START) begin
      we = !start_bad && !busy[idx] && out_free;
    end else if (state == S_TICK) begin
      we    = hit && periodic[idx] && out_free;
      wdata = {rd_tag, rd_ivl, now_t};
    end
  end

  assign req_ready = (state == S_IDLE);

  // Sequencer, slot flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      busy       <= '0;
      periodic   <= '0;
      busy_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item <= req;
            idx  <= '0;
            case (req.op)
              OP_START:  state <= S_START;
              OP_CANCEL: state <= S_CANCEL;
              OP_TICK:   state <= S_TICK;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_START: begin
          if (start_bad) begin
            if (out_free) begin
              rsp       <= '{K_START_FAIL, 6'd0, 16'd0, 1'b1};
              state     <= S_IDLE;
            end
          end else if (busy[idx]) begin
            idx <= idx + IW'(1);
          end else if (out_free) begin
            busy[idx]     <= 1'b1;
            periodic[idx] <= item.periodic;
            busy_count    <= busy_count + CW'(1);
            rsp           <= '{K_START_OK, 6'(idx), 16'd0, 1'b1};
            state         <= S_IDLE;
          end
        end
        S_CANCEL: begin
          if (out_free) begin
            if (cancel_bad) begin
              rsp <= '{K_CANCEL_FAIL, 6'd0, 16'd0, 1'b1};
            end else begin
              rsp <= '{K_CANCEL_OK, 6'd0, 16'd0, 1'b1};
              if (busy[cidx]) begin
                busy[cidx] <= 1'b0;
                busy_count <= busy_count - CW'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          if (adv) begin
            if (hit) begin
              rsp       <= '{K_FIRED, 6'(idx), rd_tag, 1'b0};
              if (!periodic[idx]) begin
                busy[idx]  <= 1'b0;
                busy_count <= busy_count - CW'(1);
              end
            end
            if (idx == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp       <= '{K_TICK_DONE, 6'd0, 16'd0, 1'b1};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Busy count always matches the number of busy slots
  a_count: assert property (@(posedge clk) disable iff (rst)
    busy_count == CW'($countones(busy)))
    else $error("busy count out of step with slot flags");

  // A fired result carries a real handler tag and a slot in range
  a_fired_tag: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == K_FIRED) |-> (rsp.tag_out != 16'd0 &&
      rsp.slot_out < 6'(SLOTS)))
    else $error("fired result with empty tag or bad slot");

  // A tick is never finished in the cycle after it is taken
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.op == OP_TICK) |=> !req_ready)
    else $error("ready again right after a tick item");

  // A fired result is never marked as the last of its item
  a_fired_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == K_FIRED) |-> !rsp.last)
    else $error("fired result marked last");

endmodule
